### hdl/va_pkg.sv
package va_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 14;

  localparam int WORK_FRAC    = 30;
  localparam int CORDIC_STEPS = 31;
  localparam int SQRT_STEPS   = 32;
  localparam int NORM_W       = 30;
  localparam int SUM_W        = 62;
  localparam int ROOT_W       = 32;
  localparam int ANGLE_W      = 16;
  localparam int XY_W         = 36;
  localparam int Z_W          = 34;

  localparam logic signed [Z_W-1:0] PI_W      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_W = 34'sd1686629713;

  typedef struct packed {
    logic              neg;
    logic              degen;
    logic [NORM_W-1:0] dm;
  } va_side_t;

  // atan(2^-i) in radians, 30 fraction bits
  function automatic logic signed [Z_W-1:0] atan_w(input logic [4:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      5'd24: a = 34'sd64;
      5'd25: a = 34'sd32;
      5'd26: a = 34'sd16;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // arithmetic shift that rounds toward zero
  function automatic logic signed [XY_W-1:0] shr0(input logic signed [XY_W-1:0] v,
                                                  input int s);
    logic signed [XY_W-1:0] n;
    n = -v;
    return v[XY_W-1] ? -(n >>> s) : (v >>> s);
  endfunction

endpackage

### hdl/va_if.sv
interface va_in_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] a_z;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface va_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_rad;
  logic        degenerate;

  modport source (output valid, angle_rad, degenerate, input ready);
  modport sink   (input valid, angle_rad, degenerate, output ready);
endinterface

### hdl/va_isqrt.sv
module va_isqrt
  import va_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  va_side_t          in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output va_side_t          out_side
);

  logic             vld_r  [SQRT_STEPS];
  logic [SUM_W-1:0] rem_r  [SQRT_STEPS];
  logic [SUM_W:0]   root_r [SQRT_STEPS];
  va_side_t         side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SUM_W:0] BIT_C = (SUM_W+1)'(1) << (SUM_W - 2*k);
    logic             vld_p;
    logic [SUM_W-1:0] rem_p;
    logic [SUM_W:0]   root_p;
    va_side_t         side_p;
    logic [SUM_W:0]   cand;
    logic             take;

    if (k == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rem_p  = in_sum;
      assign root_p = '0;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign side_p = side_r[k-1];
    end

    assign cand = root_p + BIT_C;
    assign take = {1'b0, rem_p} >= cand;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_p;
        if (take) begin
          rem_r[k]  <= rem_p - cand[SUM_W-1:0];
          root_r[k] <= (root_p >> 1) + BIT_C;
        end else begin
          rem_r[k]  <= rem_p;
          root_r[k] <= root_p >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1][ROOT_W-1:0];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

### hdl/va_cordic.sv
module va_cordic
  import va_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ROOT_W-1:0]     in_root,
  input  va_side_t              in_side,
  output logic                  out_valid,
  output logic signed [Z_W-1:0] out_z,
  output va_side_t              out_side
);

  logic                   vld_r  [CORDIC_STEPS];
  logic signed [XY_W-1:0] x_r    [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r    [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r    [CORDIC_STEPS];
  va_side_t               side_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [Z_W-1:0] ATAN_C = atan_w(5'(i));
    logic                   vld_p;
    logic signed [XY_W-1:0] x_p, y_p, xs, ys;
    logic signed [Z_W-1:0]  z_p;
    va_side_t               side_p;

    if (i == 0) begin : g_first
      assign vld_p  = in_valid;
      assign x_p    = XY_W'(in_side.dm);
      assign y_p    = XY_W'(in_root);
      assign z_p    = '0;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[i-1];
      assign x_p    = x_r[i-1];
      assign y_p    = y_r[i-1];
      assign z_p    = z_r[i-1];
      assign side_p = side_r[i-1];
    end

    assign xs = shr0(x_p, i);
    assign ys = shr0(y_p, i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end

    // rotate y toward zero, y exactly zero stops the rotation
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_p;
        if (!y_p[XY_W-1] && (y_p != '0)) begin
          x_r[i] <= x_p + ys;
          y_r[i] <= y_p - xs;
          z_r[i] <= z_p + ATAN_C;
        end else if (y_p[XY_W-1]) begin
          x_r[i] <= x_p - ys;
          y_r[i] <= y_p + xs;
          z_r[i] <= z_p - ATAN_C;
        end else begin
          x_r[i] <= x_p;
          y_r[i] <= y_p;
          z_r[i] <= z_p;
        end
      end
    end
  end

  assign out_valid = vld_r[CORDIC_STEPS-1];
  assign out_z     = z_r[CORDIC_STEPS-1];
  assign out_side  = side_r[CORDIC_STEPS-1];

endmodule

### hdl/vector_angle.sv
// channel   dir  payload
// in_ch     in   a_x a_y a_z b_x b_y b_z (signed, COMPONENT_WIDTH each)
// out_ch    out  angle_rad (16 bit, ANGLE_FRAC_BITS fraction), degenerate
//
// one pair per cycle unless the output stalls; from transfer in to result
// valid: 6 front stages (products, sums, max, normalize, squares, sum),
// 32 square root stages, 31 cordic stages and the output register.
// synchronous active low reset clears the valid bits only.
// the whole pipeline holds while the output register is full and not taken.
module vector_angle
  import va_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  va_in_if.sink    in_ch,
  va_out_if.source out_ch
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int PW  = 2*CW;
  localparam int DW  = 2*CW + 2;
  localparam int MW  = 2*CW;
  localparam int EW  = (MW > NORM_W) ? MW : NORM_W;
  localparam int SHW = $clog2(EW);
  localparam int RS  = WORK_FRAC - ANGLE_FRAC_BITS;

  logic en;

  function automatic logic [MW-1:0] f_mag(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] a;
    a = v[DW-1] ? -v : v;
    return a[MW-1:0];
  endfunction

  // stage 1: products
  logic                 v1_r, deg1_r;
  logic signed [PW-1:0] axbx_r, ayby_r, azbz_r, aybz_r, azby_r, azbx_r, axbz_r;
  logic signed [PW-1:0] axby_r, aybx_r;
  logic signed [CW-1:0] ax, ay, az, bx, by, bz;

  assign ax = CW'(in_ch.a_x);
  assign ay = CW'(in_ch.a_y);
  assign az = CW'(in_ch.a_z);
  assign bx = CW'(in_ch.b_x);
  assign by = CW'(in_ch.b_y);
  assign bz = CW'(in_ch.b_z);

  always_ff @(posedge clk) begin
    if (en) begin
      axbx_r <= ax * bx;
      ayby_r <= ay * by;
      azbz_r <= az * bz;
      aybz_r <= ay * bz;
      azby_r <= az * by;
      azbx_r <= az * bx;
      axbz_r <= ax * bz;
      axby_r <= ax * by;
      aybx_r <= ay * bx;
      deg1_r <= ((ax == '0) && (ay == '0) && (az == '0)) ||
                ((bx == '0) && (by == '0) && (bz == '0));
    end
  end

  // stage 2: dot product, cross product, magnitudes
  logic                 v2_r, deg2_r, neg2_r;
  logic [MW-1:0]        dm2_r, cx2_r, cy2_r, cz2_r;
  logic signed [DW-1:0] dot_s;

  assign dot_s = DW'(axbx_r) + DW'(ayby_r) + DW'(azbz_r);

  always_ff @(posedge clk) begin
    if (en) begin
      deg2_r <= deg1_r;
      neg2_r <= dot_s[DW-1];
      dm2_r  <= f_mag(dot_s);
      cx2_r  <= f_mag(DW'(aybz_r) - DW'(azby_r));
      cy2_r  <= f_mag(DW'(azbx_r) - DW'(axbz_r));
      cz2_r  <= f_mag(DW'(axby_r) - DW'(aybx_r));
    end
  end

  // stage 3: largest magnitude
  logic          v3_r, deg3_r, neg3_r;
  logic [MW-1:0] dm3_r, cx3_r, cy3_r, cz3_r, m3_r;
  logic [MW-1:0] m01, m23;

  assign m01 = (dm2_r > cx2_r) ? dm2_r : cx2_r;
  assign m23 = (cy2_r > cz2_r) ? cy2_r : cz2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      deg3_r <= deg2_r;
      neg3_r <= neg2_r;
      dm3_r  <= dm2_r;
      cx3_r  <= cx2_r;
      cy3_r  <= cy2_r;
      cz3_r  <= cz2_r;
      m3_r   <= (m01 > m23) ? m01 : m23;
    end
  end

  // stage 4: scale everything below 2^30
  logic              v4_r, deg4_r, neg4_r;
  logic [NORM_W-1:0] dm4_r, cx4_r, cy4_r, cz4_r;
  logic [EW-1:0]     m_ext, dm_ext, cx_ext, cy_ext, cz_ext;
  logic [EW-1:0]     dm_sh, cx_sh, cy_sh, cz_sh;
  logic [SHW-1:0]    sh;

  assign m_ext  = EW'(m3_r);
  assign dm_ext = EW'(dm3_r);
  assign cx_ext = EW'(cx3_r);
  assign cy_ext = EW'(cy3_r);
  assign cz_ext = EW'(cz3_r);

  always_comb begin
    sh = '0;
    for (int b = NORM_W; b < EW; b++) begin
      if (m_ext[b]) sh = SHW'(b - NORM_W + 1);
    end
  end

  assign dm_sh = dm_ext >> sh;
  assign cx_sh = cx_ext >> sh;
  assign cy_sh = cy_ext >> sh;
  assign cz_sh = cz_ext >> sh;

  always_ff @(posedge clk) begin
    if (en) begin
      deg4_r <= deg3_r;
      neg4_r <= neg3_r;
      dm4_r  <= dm_sh[NORM_W-1:0];
      cx4_r  <= cx_sh[NORM_W-1:0];
      cy4_r  <= cy_sh[NORM_W-1:0];
      cz4_r  <= cz_sh[NORM_W-1:0];
    end
  end

  // stage 5: squares of the cross product
  logic                v5_r;
  va_side_t            side5_r;
  logic [2*NORM_W-1:0] sqx_r, sqy_r, sqz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r <= '{neg: neg4_r, degen: deg4_r, dm: dm4_r};
      sqx_r   <= cx4_r * cx4_r;
      sqy_r   <= cy4_r * cy4_r;
      sqz_r   <= cz4_r * cz4_r;
    end
  end

  // stage 6: squared cross length
  logic             v6_r;
  va_side_t         side6_r;
  logic [SUM_W-1:0] sum6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side6_r <= side5_r;
      sum6_r  <= SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  va_side_t          sq_side;

  va_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_sum    (sum6_r),
    .in_side   (side6_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic                  cd_valid;
  logic signed [Z_W-1:0] cd_z;
  va_side_t              cd_side;

  va_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (cd_valid),
    .out_z     (cd_z),
    .out_side  (cd_side)
  );

  // output: clamp, reflect for negative dot, round to the output format
  logic                  out_valid_r, out_degen_r;
  logic [ANGLE_W-1:0]    out_angle_r;
  logic signed [Z_W-1:0] z_cl, th, th_rnd;

  always_comb begin
    z_cl = cd_z;
    if (cd_z[Z_W-1]) z_cl = '0;
    else if (cd_z > HALF_PI_W) z_cl = HALF_PI_W;
    th     = cd_side.neg ? (PI_W - z_cl) : z_cl;
    th_rnd = (th + (Z_W'(1) << (RS - 1))) >>> RS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_degen_r <= cd_side.degen;
      out_angle_r <= cd_side.degen ? '0 : th_rnd[ANGLE_W-1:0];
    end
  end

  assign en               = !out_valid_r || out_ch.ready;
  assign in_ch.ready      = en;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.angle_rad = out_angle_r;
  assign out_ch.degenerate = out_degen_r;

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |-> out_ch.angle_rad == '0)
    else $error("degenerate result with nonzero angle");

  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v6_r) && $stable(sum6_r))
    else $error("front pipeline moved during a stall");

endmodule

### verif/tb_vector_angle.sv
module tb_vector_angle
  import va_pkg::*;
;

  localparam int CW = 16;
  localparam int AFB = 14;
  localparam int N_RANDOM = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 90;

  typedef struct {
    logic [15:0] angle;
    logic        degen;
  } angle_res_t;

  typedef struct {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    bit                   known;   // expected result typed in below
    logic [15:0]          angle;
    logic                 degen;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst_n;

  va_in_if #(CW) in_ch ();
  va_out_if      out_ch ();

  vector_angle #(.COMPONENT_WIDTH(CW), .ANGLE_FRAC_BITS(AFB)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  angle_res_t angle_q[$];
  longint     atan_lut[CORDIC_STEPS];
  longint     pi_fix, half_pi_fix;
  int         mismatches = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  longint     cycles = 0;

  // atan(1/n), 60 fraction bits, alternating series
  function automatic longint unsigned atan_recip60(longint unsigned n);
    longint unsigned p, pos, neg, k, t;
    p = (64'd1 << 60) / n;
    pos = 0; neg = 0; k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) neg += t; else pos += t;
      p = p / (n * n);
      k++;
    end
    return pos - neg;
  endfunction

  function automatic longint to_work(longint unsigned v);
    return longint'((v + (64'd1 << (59 - WORK_FRAC))) >> (60 - WORK_FRAC));
  endfunction

  function automatic void build_atan_lut();
    longint unsigned pi60, pos, neg, t;
    int e;
    pi60 = 16 * atan_recip60(5) - 4 * atan_recip60(239);
    pi_fix = to_work(pi60);
    half_pi_fix = to_work(pi60 / 2);
    atan_lut[0] = to_work(pi60 / 4);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      pos = 0; neg = 0;
      for (int k = 0; ; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e < 0) break;
        t = (64'd1 << e) / longint'(2 * k + 1);
        if (k % 2) neg += t; else pos += t;
      end
      atan_lut[i] = to_work(pos - neg);
    end
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint trunc_shift(longint v, int s);
    return v < 0 ? -((-v) >>> s) : (v >>> s);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angle_res_t angle_between(pair_row_t p);
    angle_res_t res;
    longint ax, ay, az, bx, by, bz, dot, x, y, z, th, xs, ys;
    longint unsigned cx, cy, cz, dm, m, sum, rounded;
    int s;
    ax = p.ax; ay = p.ay; az = p.az; bx = p.bx; by = p.by; bz = p.bz;
    s = 0;
    if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0)) begin
      res.angle = '0;
      res.degen = 1'b1;
      return res;
    end
    dot = ax * bx + ay * by + az * bz;
    cx = abs64(ay * bz - az * by);
    cy = abs64(az * bx - ax * bz);
    cz = abs64(ax * by - ay * bx);
    dm = abs64(dot);
    m = dm;
    if (cx > m) m = cx;
    if (cy > m) m = cy;
    if (cz > m) m = cz;
    while ((m >> s) >= (64'd1 << 30)) s++;
    cx >>= s; cy >>= s; cz >>= s; dm >>= s;
    sum = cx * cx + cy * cy + cz * cz;
    x = dm;
    y = int_sqrt(sum);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = trunc_shift(x, i);
      ys = trunc_shift(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += atan_lut[i];
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z -= atan_lut[i];
      end
    end
    if (z < 0) z = 0;
    if (z > half_pi_fix) z = half_pi_fix;
    th = (dot < 0) ? pi_fix - z : z;
    rounded = longint'(th + (64'sd1 << (WORK_FRAC - AFB - 1))) >> (WORK_FRAC - AFB);
    res.angle = rounded[15:0];
    res.degen = 1'b0;
    return res;
  endfunction

  function automatic pair_row_t mk(int ax, int ay, int az, int bx, int by, int bz);
    pair_row_t p;
    p.ax = CW'(ax); p.ay = CW'(ay); p.az = CW'(az);
    p.bx = CW'(bx); p.by = CW'(by); p.bz = CW'(bz);
    p.known = 0; p.angle = '0; p.degen = 1'b0;
    return p;
  endfunction

  function automatic pair_row_t mk_exp(int ax, int ay, int az, int bx, int by, int bz,
                                      int ang, bit dg);
    pair_row_t p;
    p = mk(ax, ay, az, bx, by, bz);
    p.known = 1; p.angle = 16'(ang); p.degen = dg;
    return p;
  endfunction

  task automatic send_pair(pair_row_t p);
    angle_res_t e;
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_x <= p.ax; in_ch.a_y <= p.ay; in_ch.a_z <= p.az;
    in_ch.b_x <= p.bx; in_ch.b_y <= p.by; in_ch.b_z <= p.bz;
    do @(posedge clk); while (!in_ch.ready);
    if (p.known) begin
      e.angle = p.angle; e.degen = p.degen;
    end else begin
      e = angle_between(p);
    end
    angle_q.push_back(e);
  endtask

  function automatic logic signed [CW-1:0] rnd_comp(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return CW'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic pair_row_t rnd_pair();
    pair_row_t p;
    int kind, mode, k;
    kind = $urandom_range(99);
    mode = $urandom_range(3);
    p = mk(rnd_comp(mode), rnd_comp(mode), rnd_comp(mode),
           rnd_comp(mode), rnd_comp(mode), rnd_comp(mode));
    if (kind < 15) begin
      // 2d pair
      p.az = 0; p.bz = 0;
    end else if (kind < 30) begin
      // parallel or antiparallel by a small integer factor
      p = mk(rnd_comp(1), rnd_comp(1), rnd_comp(1), 0, 0, 0);
      k = $urandom_range(1, 500) * ($urandom_range(1) ? 1 : -1);
      p.bx = CW'(p.ax * k); p.by = CW'(p.ay * k); p.bz = CW'(p.az * k);
    end else if (kind < 38) begin
      // perpendicular in the xy plane
      p.bx = -p.ay; p.by = p.ax; p.bz = 0; p.az = 0;
    end else if (kind < 42) begin
      if ($urandom_range(1)) begin
        p.ax = 0; p.ay = 0; p.az = 0;
      end else begin
        p.bx = 0; p.by = 0; p.bz = 0;
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    angle_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result angle=%0d degenerate=%0b",
                   out_ch.angle_rad, out_ch.degenerate);
      end else begin
        e = angle_q.pop_front();
        if (out_ch.angle_rad !== e.angle || out_ch.degenerate !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected angle=%0d degenerate=%0b, ",
                      "got angle=%0d degenerate=%0b"},
                     e.angle, e.degen, out_ch.angle_rad, out_ch.degenerate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  pair_row_t directed[$];

  initial begin
    int phase;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.a_x <= '0; in_ch.a_y <= '0; in_ch.a_z <= '0;
    in_ch.b_x <= '0; in_ch.b_y <= '0; in_ch.b_z <= '0;
    build_atan_lut();
    directed = '{
      mk_exp(0, 0, 0, 0, 0, 0, 0, 1),
      mk_exp(0, 0, 0, 5, -3, 7, 0, 1),
      mk_exp(32767, -32768, 1, 0, 0, 0, 0, 1),
      mk_exp(1, 0, 0, 1, 0, 0, 0, 0),
      mk_exp(1, 0, 0, -1, 0, 0, 51472, 0),
      mk_exp(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0),
      mk_exp(32767, 32767, 32767, 32767, 32767, 32767, 0, 0),
      mk_exp(-32768, -32768, -32768, 32767, 32767, 32767, 51472, 0),
      mk_exp(3, -4, 5, -6, 8, -10, 51472, 0),
      mk(1, 0, 0, 0, 1, 0),
      mk(0, 0, 1, 1, 1, 0),
      mk(1, 1, 0, 1, 0, 0),
      mk(1, 1, 0, -1, 0, 0),
      mk(32767, 0, 0, 32767, 1, 0),
      mk(32767, 0, 0, -32768, 1, 0),
      mk(-32768, 32767, -32768, 32767, -32768, 32767),
      mk(32767, -32768, 0, 32767, 32767, 0),
      mk(1, 2, 3, 4, 5, 6),
      mk(-1, -1, -1, 1, 1, -1),
      mk(12345, -23456, 30000, -7, 9, 11)
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_pair(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      phase = (n * 4) / N_RANDOM;
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      if (n == N_RANDOM / 2) begin
        // hold off until the pipeline has fully drained
        in_ch.valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge clk);
      end
      send_pair(rnd_pair());
    end
    in_ch.valid <= 1'b0;

    while (angle_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hdl/va_pkg.sv
hdl/va_if.sv
hdl/va_isqrt.sv
hdl/va_cordic.sv
hdl/vector_angle.sv
verif/tb_vector_angle.sv
